/* hdl/ffwc_pkg.sv */
package ffwc_pkg;

  // input word action codes
  typedef enum logic [1:0] {
    ACT_CAL     = 2'd0,
    ACT_CORRECT = 2'd1,
    ACT_CLEAR   = 2'd2
  } ffwc_action_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MIN  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } ffwc_state_e;

  // divider control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } ffwc_div_ctrl_t;

  // channel index of the last multiply
  localparam logic [1:0] ChLast = 2'd2;

endpackage

/* hdl/ffwc_div.sv */
module ffwc_div
  import ffwc_pkg::*;
#(
  parameter int unsigned W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ffwc_div_ctrl_t            ctrl_i,
  input  logic [2:0][2*W-1:0]       prod_i,
  input  logic [2:0][W-1:0]         den_i,
  output logic [2:0][W-1:0]         res_o,
  output logic                      clip_o
);

  logic [2:0][W-1:0] rem_q;
  logic [2:0][W-1:0] lq_q;
  logic [2:0][W-1:0] den_q;
  logic [2:0]        sat_q;

  logic [2:0][W:0]   trial;
  logic [2:0][W:0]   diff;
  logic [2:0]        ge;
  logic [2:0]        sat_d;

  // one restoring step per lane, plus the overflow test on load
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_q[i], lq_q[i][W-1]};
      ge[i]    = trial[i] >= {1'b0, den_q[i]};
      diff[i]  = trial[i] - {1'b0, den_q[i]};
      // quotient overflows when the high half reaches the divisor (zero divisor too)
      sat_d[i] = prod_i[i][2*W-1:W] >= den_i[i];
    end
  end

  // remainder and shared dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= prod_i[i][2*W-1:W];
        lq_q[i]  <= prod_i[i][W-1:0];
        den_q[i] <= den_i[i];
      end
      sat_q <= sat_d;
    end else if (ctrl_i.step) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= ge[i] ? diff[i][W-1:0] : trial[i][W-1:0];
        lq_q[i]  <= {lq_q[i][W-2:0], ge[i]};
      end
    end
  end

  // saturate to full scale
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_o[i] = sat_q[i] ? {W{1'b1}} : lq_q[i];
    end
  end
  assign clip_o = |sat_q;

  // remainder of a live lane stays below its divisor
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> ((sat_q[0] || rem_q[0] < den_q[0]) &&
                     (sat_q[1] || rem_q[1] < den_q[1]) &&
                     (sat_q[2] || rem_q[2] < den_q[2])))
    else $error("divider remainder out of range");

endmodule

/* hdl/flat_field_white_correction_core.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o | action_i, pix_*_i, white_*_i
// out     | output    | out_valid_o / out_ready_i | out_r_o, out_g_o, out_b_o, clipped_o
//
// calibrate and clear words leave the input ready; a correct word holds the input
// through min select, three multiplies on one multiplier, divider load,
// SAMPLE_BITS radix-2 steps and the output load, which waits for a free output.
// reset clears the channel maxima.
// the output register frees the input: a new word is taken while a result waits.
module flat_field_white_correction_core
  import ffwc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             action_i,
  input  logic [SAMPLE_BITS-1:0] pix_r_i,
  input  logic [SAMPLE_BITS-1:0] pix_g_i,
  input  logic [SAMPLE_BITS-1:0] pix_b_i,
  input  logic [SAMPLE_BITS-1:0] white_r_i,
  input  logic [SAMPLE_BITS-1:0] white_g_i,
  input  logic [SAMPLE_BITS-1:0] white_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] out_r_o,
  output logic [SAMPLE_BITS-1:0] out_g_o,
  output logic [SAMPLE_BITS-1:0] out_b_o,
  output logic                   clipped_o
);

  localparam int unsigned W  = SAMPLE_BITS;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CntLast = CW'(W - 1);

  ffwc_state_e state_q, state_d;
  logic [1:0]    ch_q;
  logic [CW-1:0] cnt_q;

  logic [W-1:0] max_r_q, max_g_q, max_b_q;
  logic [W-1:0] m_q, m_d;
  logic [2:0][W-1:0]   pix_q;
  logic [2:0][W-1:0]   wht_q;
  logic [2:0][2*W-1:0] prod_q;
  logic [2*W-1:0]      mul_res;

  ffwc_div_ctrl_t    div_ctrl;
  logic [2:0][W-1:0] div_res;
  logic              div_clip;

  logic out_valid_q;
  logic [W-1:0] out_r_q, out_g_q, out_b_q;
  logic out_clip_q;

  logic in_acc;
  logic out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && action_i == ACT_CORRECT) state_d = ST_MIN;
      end
      ST_MIN:  state_d = ST_MUL;
      ST_MUL: begin
        if (ch_q == ChLast) state_d = ST_LOAD;
      end
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CntLast) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) ch_q <= (ch_q == ChLast) ? '0 : ch_q + 2'd1;
      if (state_q == ST_DIV) cnt_q <= (cnt_q == CntLast) ? '0 : cnt_q + CW'(1);
    end
  end

  // channel maxima: calibrate raises, clear zeroes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_r_q <= '0;
      max_g_q <= '0;
      max_b_q <= '0;
    end else if (in_acc) begin
      case (action_i)
        ACT_CAL: begin
          if (white_r_i > max_r_q) max_r_q <= white_r_i;
          if (white_g_i > max_g_q) max_g_q <= white_g_i;
          if (white_b_i > max_b_q) max_b_q <= white_b_i;
        end
        ACT_CLEAR: begin
          max_r_q <= '0;
          max_g_q <= '0;
          max_b_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // capture the pixel and white samples of a correct word
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_CORRECT) begin
      pix_q <= {pix_b_i, pix_g_i, pix_r_i};
      wht_q <= {white_b_i, white_g_i, white_r_i};
    end
  end

  // least of the three maxima
  always_comb begin
    m_d = max_r_q;
    if (max_g_q < m_d) m_d = max_g_q;
    if (max_b_q < m_d) m_d = max_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MIN) m_q <= m_d;
  end

  // one multiplier, one channel per cycle
  assign mul_res = {{W{1'b0}}, pix_q[ch_q]} * {{W{1'b0}}, m_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) prod_q[ch_q] <= mul_res;
  end

  assign div_ctrl.load = (state_q == ST_LOAD);
  assign div_ctrl.step = (state_q == ST_DIV);

  ffwc_div #(
    .W (W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .prod_i (prod_q),
    .den_i  (wht_q),
    .res_o  (div_res),
    .clip_o (div_clip)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_r_q    <= div_res[0];
      out_g_q    <= div_res[1];
      out_b_q    <= div_res[2];
      out_clip_q <= div_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_r_o     = out_r_q;
  assign out_g_o     = out_g_q;
  assign out_b_o     = out_b_q;
  assign clipped_o   = out_clip_q;

  // a correct word blocks the input on the next cycle
  a_busy_after_correct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_CORRECT) |=> !in_ready_o)
    else $error("input ready while correcting");

  // calibrate never lowers a maximum
  a_max_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_CAL) |=>
      (max_r_q >= $past(max_r_q) && max_g_q >= $past(max_g_q) &&
       max_b_q >= $past(max_b_q)))
    else $error("channel maximum decreased");

  // a new result only comes out of the output state
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result word without a finished division");

endmodule

/* verif/ffwc_correction_checker.sv */
`timescale 1ns / 1ps

module ffwc_correction_checker
  import ffwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] pix_r_i,
  input  logic [15:0] pix_g_i,
  input  logic [15:0] pix_b_i,
  input  logic [15:0] white_r_i,
  input  logic [15:0] white_g_i,
  input  logic [15:0] white_b_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_r_i,
  input  logic [15:0] out_g_i,
  input  logic [15:0] out_b_i,
  input  logic        clipped_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned checked_cnt_o,
  output int unsigned clipped_cnt_o
);

  localparam logic [15:0] FullScale  = 16'hFFFF;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        clipped;
  } pixel_t;

  logic [15:0] white_peak_r;
  logic [15:0] white_peak_g;
  logic [15:0] white_peak_b;
  pixel_t      pending_pixels[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned clipped_seen;

  // one channel: floor(pix * m / white), saturated; clip flag in the top bit
  function automatic logic [16:0] scale_channel(input logic [15:0] pix,
                                                input logic [15:0] white,
                                                input logic [15:0] m);
    logic [31:0] quotient;
    if (white == '0) return {1'b1, FullScale};
    quotient = (32'(pix) * 32'(m)) / 32'(white);
    if (quotient > 32'(FullScale)) return {1'b1, FullScale};
    return {1'b0, quotient[15:0]};
  endfunction

  // corrected pixel from the current channel maxima
  function automatic pixel_t correct_pixel(input logic [15:0] pr, input logic [15:0] pg,
                                           input logic [15:0] pb, input logic [15:0] wr,
                                           input logic [15:0] wg, input logic [15:0] wb);
    logic [15:0] m;
    logic [16:0] cr;
    logic [16:0] cg;
    logic [16:0] cb;
    pixel_t      px;
    m = white_peak_r;
    if (white_peak_g < m) m = white_peak_g;
    if (white_peak_b < m) m = white_peak_b;
    cr = scale_channel(pr, wr, m);
    cg = scale_channel(pg, wg, m);
    cb = scale_channel(pb, wb, m);
    px.r       = cr[15:0];
    px.g       = cg[15:0];
    px.b       = cb[15:0];
    px.clipped = cr[16] | cg[16] | cb[16];
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : l_track
    pixel_t exp_px;
    pixel_t got_px;
    if (!rst_ni) begin
      white_peak_r = '0;
      white_peak_g = '0;
      white_peak_b = '0;
      pending_pixels.delete();
      mismatches   = 0;
      checked      = 0;
      clipped_seen = 0;
    end else begin
      // result word: compare against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got_px = '{r: out_r_i, g: out_g_i, b: out_b_i, clipped: clipped_i};
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: unexpected result word r=%h g=%h b=%h clipped=%b",
                     $realtime, got_px.r, got_px.g, got_px.b, got_px.clipped);
        end else begin
          exp_px = pending_pixels.pop_front();
          checked++;
          if (exp_px.clipped) clipped_seen++;
          if (got_px != exp_px) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: mismatch exp r=%h g=%h b=%h clipped=%b, got r=%h g=%h b=%h clipped=%b",
                       $realtime, exp_px.r, exp_px.g, exp_px.b, exp_px.clipped,
                       got_px.r, got_px.g, got_px.b, got_px.clipped);
          end
        end
      end
      // input word: track maxima or predict a corrected pixel
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_CAL: begin
            if (white_r_i > white_peak_r) white_peak_r = white_r_i;
            if (white_g_i > white_peak_g) white_peak_g = white_g_i;
            if (white_b_i > white_peak_b) white_peak_b = white_b_i;
          end
          ACT_CORRECT: begin
            pending_pixels.push_back(correct_pixel(pix_r_i, pix_g_i, pix_b_i,
                                                   white_r_i, white_g_i, white_b_i));
          end
          ACT_CLEAR: begin
            white_peak_r = '0;
            white_peak_g = '0;
            white_peak_b = '0;
          end
          default: begin
          end
        endcase
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_cnt_o  <= pending_pixels.size();
    checked_cnt_o  <= checked;
    clipped_cnt_o  <= clipped_seen;
  end

endmodule

/* verif/flat_field_white_correction_core_tb.sv */
`timescale 1ns / 1ps

module flat_field_white_correction_core_tb
  import ffwc_pkg::*;
();

  localparam int unsigned RandomWords = 480;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam logic [1:0]  ActUnused   = 2'd3;
  localparam logic [15:0] FullScale   = 16'hFFFF;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  action_i    = ACT_CAL;
  logic [15:0] pix_r_i     = '0;
  logic [15:0] pix_g_i     = '0;
  logic [15:0] pix_b_i     = '0;
  logic [15:0] white_r_i   = '0;
  logic [15:0] white_g_i   = '0;
  logic [15:0] white_b_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] out_r_o;
  logic [15:0] out_g_o;
  logic [15:0] out_b_o;
  logic        clipped_o;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned clipped_cnt;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_sent[4];
  int unsigned total_sent = 0;

  flat_field_white_correction_core #(
    .SAMPLE_BITS(16)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .pix_r_i    (pix_r_i),
    .pix_g_i    (pix_g_i),
    .pix_b_i    (pix_b_i),
    .white_r_i  (white_r_i),
    .white_g_i  (white_g_i),
    .white_b_i  (white_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_r_o    (out_r_o),
    .out_g_o    (out_g_o),
    .out_b_o    (out_b_o),
    .clipped_o  (clipped_o)
  );

  ffwc_correction_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .pix_r_i       (pix_r_i),
    .pix_g_i       (pix_g_i),
    .pix_b_i       (pix_b_i),
    .white_r_i     (white_r_i),
    .white_g_i     (white_g_i),
    .white_b_i     (white_b_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_r_i       (out_r_o),
    .out_g_i       (out_g_o),
    .out_b_i       (out_b_o),
    .clipped_i     (clipped_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt),
    .checked_cnt_o (checked_cnt),
    .clipped_cnt_o (clipped_cnt)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  // sample biased toward the edges of the range
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FullScale;
      2: return 16'($urandom_range(1, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  // white reference for calibration, mostly bright
  function automatic logic [15:0] rand_white();
    if ($urandom_range(0, 3) == 0) return rand_sample();
    return 16'($urandom_range(16'h4000, 16'hFFFF));
  endfunction

  // present one input word and hold it until accepted
  task automatic send_word(input logic [1:0] act,
                           input logic [15:0] pr, input logic [15:0] pg, input logic [15:0] pb,
                           input logic [15:0] wr, input logic [15:0] wg, input logic [15:0] wb);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pix_r_i    <= pr;
    pix_g_i    <= pg;
    pix_b_i    <= pb;
    white_r_i  <= wr;
    white_g_i  <= wg;
    white_b_i  <= wb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent[act]++;
    total_sent++;
  endtask

  // optional clear, a calibration run, then corrections, sometimes noise
  task automatic run_burst();
    int unsigned n_cal;
    int unsigned n_fix;
    if ($urandom_range(0, 3) == 0)
      send_word(ACT_CLEAR, rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), rand_sample(), rand_sample());
    n_cal = $urandom_range(1, 6);
    repeat (n_cal)
      send_word(ACT_CAL, rand_sample(), rand_sample(), rand_sample(),
                rand_white(), rand_white(), rand_white());
    n_fix = $urandom_range(1, 10);
    repeat (n_fix)
      send_word(ACT_CORRECT, rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), rand_sample(), rand_sample());
    if ($urandom_range(0, 2) == 0)
      send_word(2'($urandom_range(0, 3)), rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), rand_sample(), rand_sample());
  endtask

  initial begin : l_stimulus
    int unsigned target;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // not calibrated: maxima still zero
    send_word(ACT_CORRECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0002, 16'hFFFF);
    send_word(ACT_CORRECT, 16'h0000, 16'h1234, 16'h0000, 16'h0000, 16'h0005, 16'h0000);
    // full-scale white reference, saturation and zero white
    send_word(ACT_CAL, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_CORRECT, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_CORRECT, 16'hFFFF, 16'h8000, 16'h0001, 16'h0001, 16'h8000, 16'h0000);
    send_word(ACT_CORRECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // unused action must leave the maxima alone
    send_word(ActUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001);
    send_word(ACT_CORRECT, 16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_CORRECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001);
    // least maximum taken from each channel in turn
    send_word(ACT_CAL, 16'h0000, 16'h0000, 16'h0000, 16'h9000, 16'h9000, 16'h0400);
    send_word(ACT_CORRECT, 16'h0200, 16'h0400, 16'h0800, 16'h0400, 16'h0400, 16'h0400);
    send_word(ACT_CAL, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'hA000);
    send_word(ACT_CORRECT, 16'h8000, 16'h4000, 16'h2000, 16'h9000, 16'hA000, 16'h1000);
    send_word(ACT_CAL, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hC000, 16'hFFFF);
    send_word(ACT_CORRECT, 16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'hFFFF, 16'h8000);
    send_word(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_CAL, 16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h3000, 16'h4000);
    send_word(ACT_CAL, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h5000, 16'h0000);
    send_word(ACT_CORRECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h2000, 16'h3000, 16'h4000);
    send_word(ACT_CORRECT, 16'h5555, 16'hAAAA, 16'h0001, 16'h0001, 16'hFFFF, 16'h2000);

    // random bursts over four idle/stall phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 77;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 77;
        end
        default: begin
          idle_pct = 20;
          stall_pct <= 20;
        end
      endcase
      target = total_sent + RandomWords / 4;
      while (total_sent < target) run_burst();
    end

    // drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d words: %0d calibrate, %0d correct, %0d clear, %0d unused",
             total_sent, words_sent[ACT_CAL], words_sent[ACT_CORRECT],
             words_sent[ACT_CLEAR], words_sent[ActUnused]);
    $display("checked %0d corrected pixels (%0d clipped) across four idle/stall phases",
             checked_cnt, clipped_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
